@@ sv/lis_pkg.sv @@
// shared constants and types for the longest increasing subsequence block
`default_nettype none

package lis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int LEN_W     = $clog2(MAX_ITEMS + 1);
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    // one stored entry: value, best length ending here, predecessor index
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] pred;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_WRITE   = 9'b000000100,
        S_TR_RD   = 9'b000001000,
        S_TR_WT   = 9'b000010000,
        S_EM_CH   = 9'b000100000,
        S_EM_VAL  = 9'b001000000,
        S_EM_LOAD = 9'b010000000,
        S_EM_OUT  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

@@ sv/longest_increasing_subsequence.sv @@
// top level: longest strictly increasing subsequence over a stream of signed values
// a stored item keeps tready low after its transfer while the scan reads each earlier
// entry, settles and then writes the new entry; a last item then adds the predecessor
// walk and the output of the subsequence, element by element (one entry read port)
// synchronous active-low reset clears run count, drop flag and control; rams need no clear
`default_nettype none

module longest_increasing_subsequence
    import lis_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [31:0] value
    input  wire logic                   i_s_axis_tlast,   // last item of the sequence
    // result stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [31:0] element, [37:32] position,
                                                          // [44:38] seq_length,
                                                          // [45] overflowed, [47:46] zero
    output logic                        o_m_axis_tlast    // end_of_run
);

    // control and run state
    t_state           r_state,   n_state;
    logic [VAL_W-1:0] r_val,     n_val;      // value being inserted
    logic             r_last,    n_last;
    logic [LEN_W-1:0] r_count,   n_count;    // entries stored in this run
    logic             r_drop,    n_drop;     // an item was dropped for capacity
    logic [LEN_W-1:0] r_best,    n_best;     // best length among smaller earlier entries
    logic [IDX_W-1:0] r_pred,    n_pred;
    logic [LEN_W-1:0] r_max_len, n_max_len;  // running longest length of the run
    logic [IDX_W-1:0] r_endpos,  n_endpos;   // earliest entry holding that length
    logic [LEN_W-1:0] r_rd_idx,  n_rd_idx;   // scan read pointer, can reach the count
    logic             r_rd_vld,  n_rd_vld;   // a scan read returns this cycle
    logic [IDX_W-1:0] r_cur,     n_cur;      // walk pointer through predecessors
    logic [IDX_W-1:0] r_k,       n_k;        // chain slot
    logic                   r_out_vld,  n_out_vld;
    logic                   r_out_last, n_out_last;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // ram ports
    logic             w_ent_we;
    logic [IDX_W-1:0] w_ent_raddr;
    t_entry           w_ent_wdata;
    t_entry           w_ent_rdata;
    logic [IDX_W-1:0] w_chain_rdata;
    logic             w_chain_we;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_rd_en;
    logic             w_hit;
    logic [LEN_W-1:0] w_new_len;
    logic [LEN_W-1:0] w_k_next;

    // entry store: value, length and predecessor of every item of the run
    lis_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ITEMS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // chain store: entry indices of the subsequence, filled back to front
    lis_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ITEMS)
    ) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (w_chain_we),
        .i_waddr (r_k),
        .i_wdata (r_cur),
        .i_raddr (r_k),
        .o_rdata (w_chain_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer      = r_out_vld && i_m_axis_tready;

    // scan keeps issuing reads until every earlier entry has been asked for
    assign w_rd_en = (r_state == S_SCAN) && (r_rd_idx < r_count);

    // earlier entry strictly smaller and strictly longer: earliest tie wins
    assign w_hit = r_rd_vld
                && ($signed(w_ent_rdata.value) < $signed(r_val))
                && (w_ent_rdata.len > r_best);

    assign w_new_len = r_best + LEN_W'(1);
    assign w_k_next  = {1'b0, r_k} + LEN_W'(1);

    assign w_ent_we          = (r_state == S_WRITE);
    assign w_ent_wdata.value = r_val;
    assign w_ent_wdata.len   = w_new_len;
    assign w_ent_wdata.pred  = r_pred;
    assign w_chain_we        = (r_state == S_TR_RD);

    // entry read address follows the phase of the work
    always_comb begin
        unique case (r_state)
            S_SCAN:   w_ent_raddr = r_rd_idx[IDX_W-1:0];
            S_EM_VAL: w_ent_raddr = w_chain_rdata;
            default:  w_ent_raddr = r_cur;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_val      = r_val;
        n_last     = r_last;
        n_count    = r_count;
        n_drop     = r_drop;
        n_best     = r_best;
        n_pred     = r_pred;
        n_max_len  = r_max_len;
        n_endpos   = r_endpos;
        n_rd_idx   = r_rd_idx;
        n_rd_vld   = 1'b0;
        n_cur      = r_cur;
        n_k        = r_k;
        n_out_vld  = r_out_vld;
        n_out_last = r_out_last;
        n_out_data = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_val  = i_s_axis_tdata[VAL_W-1:0];
                    n_last = i_s_axis_tlast;
                    if (r_count < LEN_W'(MAX_ITEMS)) begin
                        n_best   = '0;
                        n_pred   = '0;
                        n_rd_idx = '0;
                        n_state  = S_SCAN;
                    end else begin
                        // full: drop the item, still emit if it closes the run
                        n_drop = 1'b1;
                        if (i_s_axis_tlast) begin
                            n_cur   = r_endpos;
                            n_k     = IDX_W'(r_max_len - LEN_W'(1));
                            n_state = S_TR_RD;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld = w_rd_en;
                if (w_rd_en) begin
                    n_rd_idx = r_rd_idx + LEN_W'(1);
                end
                if (w_hit) begin
                    n_best = w_ent_rdata.len;
                    n_pred = IDX_W'(r_rd_idx - LEN_W'(1));
                end
                if (!w_rd_en && !r_rd_vld) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_count = r_count + LEN_W'(1);
                if (w_new_len > r_max_len) begin
                    n_max_len = w_new_len;
                    n_endpos  = r_count[IDX_W-1:0];
                end
                if (r_last) begin
                    if (w_new_len > r_max_len) begin
                        n_cur = r_count[IDX_W-1:0];
                        n_k   = IDX_W'(r_best);
                    end else begin
                        n_cur = r_endpos;
                        n_k   = IDX_W'(r_max_len - LEN_W'(1));
                    end
                    n_state = S_TR_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TR_RD: begin
                // chain slot written now, predecessor read returns next cycle
                n_state = S_TR_WT;
            end
            S_TR_WT: begin
                n_cur = w_ent_rdata.pred;
                if (r_k == '0) begin
                    n_state = S_EM_CH;
                end else begin
                    n_k     = r_k - IDX_W'(1);
                    n_state = S_TR_RD;
                end
            end
            S_EM_CH: begin
                n_state = S_EM_VAL;
            end
            S_EM_VAL: begin
                n_state = S_EM_LOAD;
            end
            S_EM_LOAD: begin
                n_out_data = {2'b00, r_drop, r_max_len, r_k, w_ent_rdata.value};
                n_out_last = (w_k_next == r_max_len);
                n_out_vld  = 1'b1;
                n_state    = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (w_out_xfer) begin
                    n_out_vld = 1'b0;
                    if (r_out_last) begin
                        // run closed: next transfer starts a new sequence
                        n_count   = '0;
                        n_drop    = 1'b0;
                        n_max_len = '0;
                        n_endpos  = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_EM_CH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_max_len <= '0;
            r_endpos  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_max_len <= n_max_len;
            r_endpos  <= n_endpos;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_last     <= n_last;
        r_best     <= n_best;
        r_pred     <= n_pred;
        r_rd_idx   <= n_rd_idx;
        r_cur      <= n_cur;
        r_k        <= n_k;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ sv/lis_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module lis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/lis_chk.sv @@
// port-level checker for the longest increasing subsequence block, with its bind
`default_nettype none

module lis_chk
    import lis_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tlast
);

    logic [IDX_W-1:0] w_pos;
    logic [LEN_W-1:0] w_len;

    assign w_pos = o_m_axis_tdata[VAL_W +: IDX_W];
    assign w_len = o_m_axis_tdata[VAL_W + IDX_W +: LEN_W];

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // no new input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input taken during output");

    // position stays inside the reported length
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({1'b0, w_pos} < w_len))
        else $error("position beyond length");

    // end of run sits on the final position
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> ({1'b0, w_pos} + LEN_W'(1) == w_len))
        else $error("end of run on wrong position");

    // reset empties the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind longest_increasing_subsequence lis_chk u_lis_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the longest increasing subsequence stream block
`timescale 1ns / 1ps

module tb_top;
    import lis_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned TAIL_CYCLES = 600;
    localparam int unsigned RANDOM_ITEMS = 32;

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic [IDX_W-1:0] position;
        logic [LEN_W-1:0] seq_length;
        logic             overflowed;
        logic             end_of_run;
    } t_lis_result;

    // keeps its own copy of the entry store and predicts the emitted chain
    class lis_scoreboard;
        logic [VAL_W-1:0] seen_vals [MAX_ITEMS];
        logic [LEN_W-1:0] chain_lens[MAX_ITEMS];
        logic [IDX_W-1:0] back_links[MAX_ITEMS];
        int unsigned      held;
        bit               dropped;
        t_lis_result      awaited[$];
        int unsigned      errors, results_seen, runs, items, drops, longest;

        function void note_input(input logic [VAL_W-1:0] v, input logic l);
            logic [LEN_W-1:0] best;
            logic [IDX_W-1:0] link;
            int unsigned      tail_pos, cur;
            int unsigned      walk[MAX_ITEMS];
            t_lis_result      r;
            items++;
            if (held < MAX_ITEMS) begin
                best = '0;
                link = '0;
                for (int unsigned j = 0; j < held; j++) begin
                    if ($signed(seen_vals[j]) < $signed(v) && chain_lens[j] > best) begin
                        best = chain_lens[j];
                        link = IDX_W'(j);
                    end
                end
                seen_vals[held]  = v;
                chain_lens[held] = best + 1'b1;
                back_links[held] = link;
                held++;
            end else begin
                dropped = 1'b1;
                drops++;
            end
            if (l) begin
                // earliest position holding the greatest length ends the chain
                tail_pos = 0;
                for (int unsigned i = 1; i < held; i++)
                    if (chain_lens[i] > chain_lens[tail_pos]) tail_pos = i;
                cur = tail_pos;
                for (int k = int'(chain_lens[tail_pos]); k > 0; k--) begin
                    walk[k-1] = cur;
                    cur = back_links[cur];
                end
                for (int unsigned k = 0; k < chain_lens[tail_pos]; k++) begin
                    r.element    = seen_vals[walk[k]];
                    r.position   = IDX_W'(k);
                    r.seq_length = chain_lens[tail_pos];
                    r.overflowed = dropped;
                    r.end_of_run = (k + 1 == chain_lens[tail_pos]);
                    awaited = {awaited, r};
                end
                if (chain_lens[tail_pos] > longest) longest = chain_lens[tail_pos];
                runs++;
                held    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(input logic [OUT_TDATA_W-1:0] d, input logic l);
            t_lis_result got, want;
            got.element    = d[31:0];
            got.position   = d[37:32];
            got.seq_length = d[44:38];
            got.overflowed = d[45];
            got.end_of_run = l;
            results_seen++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result: element %0d position %0d length %0d",
                             $realtime, $signed(got.element), got.position, got.seq_length);
                return;
            end
            want = awaited.pop_front();
            if (got.element !== want.element || got.position !== want.position ||
                got.seq_length !== want.seq_length || got.overflowed !== want.overflowed ||
                got.end_of_run !== want.end_of_run) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t mismatch: element %0d/%0d position %0d/%0d length %0d/%0d",
                             $realtime, $signed(want.element), $signed(got.element),
                             want.position, got.position, want.seq_length, got.seq_length);
                    $display("    overflowed %0b/%0b end_of_run %0b/%0b (expected/actual)",
                             want.overflowed, got.overflowed, want.end_of_run, got.end_of_run);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    lis_scoreboard          lis_sb = new();
    int unsigned            cycle_count = 0;
    int unsigned            burst_left  = 0;
    bit                     long_hold_done = 1'b0;
    logic [VAL_W-1:0]       run_buf[$];
    logic [VAL_W-1:0]       trend_val;

    longest_increasing_subsequence DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, lis_sb.awaited.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            lis_sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
    end

    // result side: own stall pattern, plus one long hold-off once results flow
    initial begin : sink
        int unsigned n;
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && lis_sb.results_seen >= 3) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            n = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                1: begin
                    repeat (n) begin
                        m_tready <= ~m_tready;
                        @(posedge i_clk);
                    end
                end
                2: begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
                default: begin
                    m_tready <= 1'b1;
                    @(posedge i_clk);
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end
            endcase
        end
    end

    task automatic offer(input logic [VAL_W-1:0] v, input logic l);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        lis_sb.note_input(v, l);
        burst_left--;
    endtask

    task automatic send_run();
        foreach (run_buf[i]) offer(run_buf[i], i == run_buf.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (lis_sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input int unsigned mode);
        case (mode)
            0: return $urandom;
            1: return VAL_W'(int'($urandom_range(0, 15)) - 8);
            2: begin
                // mostly rising walk with ties and dips
                trend_val = trend_val + VAL_W'(int'($urandom_range(0, 40)) - 8);
                return trend_val;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    initial begin : stimulus
        int unsigned      run_len, mode, random_items;
        bit               long_run_done;
        logic [VAL_W-1:0] climb;
        random_items  = 0;
        long_run_done = 1'b0;
        trend_val     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, strict ordering, earliest-wins choices
        run_buf = '{32'h7FFF_FFFF};
        send_run();
        run_buf = '{32'h8000_0000, 32'h7FFF_FFFF};
        send_run();
        run_buf = '{5, 4, 3};
        send_run();
        run_buf = '{7, 7, 7};
        send_run();
        run_buf = '{2, 1, 3};
        send_run();
        run_buf = '{3, 1, 2, 0, 4};
        send_run();
        run_buf = '{-1, -5, -3, 0};
        send_run();
        wait_drained();

        while (random_items < RANDOM_ITEMS || !long_run_done) begin
            if (!long_run_done && random_items >= RANDOM_ITEMS / 2) begin
                // full store of rising values, then one dropped item and a dropped last
                run_buf = {};
                climb = 32'h8000_0000 + VAL_W'($urandom_range(0, 1000));
                repeat (MAX_ITEMS) begin
                    run_buf = {run_buf, climb};
                    climb = climb + VAL_W'($urandom_range(1, 1 << 25));
                end
                run_buf = {run_buf, VAL_W'($urandom)};
                run_buf = {run_buf, VAL_W'($urandom)};
                send_run();
                long_run_done = 1'b1;
                wait_drained();
            end else begin
                run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 10);
                mode = $urandom_range(0, 5);
                trend_val = $urandom;
                run_buf = {};
                repeat (run_len) run_buf = {run_buf, pick_value(mode > 3 ? 2 : mode)};
                send_run();
                random_items += run_len;
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d runs from %0d items, %0d results, %0d items dropped at capacity",
                 lis_sb.runs, lis_sb.items, lis_sb.results_seen, lis_sb.drops);
        $display("longest chain %0d, failures %0d", lis_sb.longest, lis_sb.errors);
        if (lis_sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
